@@ design/dtg_pkg.sv @@
// Package for the dual-tone generator: widths, register codes, reset values,
// the configuration bundle and the quarter-wave sine builder. No dependencies.
`timescale 1ns / 1ps

package dtg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int TABLE_ADDR_BITS_DEF = 10;

  localparam int STEP_W   = 32;
  localparam int AMP_W    = 15;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W    = 32;
  localparam int SINE_W   = 16;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd8000;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_STEP_ONE = 2'd0,
    CFG_STEP_TWO = 2'd1,
    CFG_AMP_ONE  = 2'd2,
    CFG_AMP_TWO  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [STEP_W-1:0] step_one;
    logic [STEP_W-1:0] step_two;
    logic [AMP_W-1:0]  amp_one;
    logic [AMP_W-1:0]  amp_two;
  } dtg_cfg_t;

  // Sine of r/2^(addr_bits-2) of a quarter turn in Q15, from an eleventh-order
  // Taylor series in Q30. Evaluated at elaboration only.
  function automatic logic [AMP_W-1:0] quarter_sine(input int unsigned r,
                                                    input int unsigned addr_bits);
    logic [63:0]        u;
    logic [63:0]        t;
    logic [63:0]        t2;
    logic [63:0]        term;
    logic [63:0]        q15;
    logic signed [63:0] sum;
    u    = 64'(r) << (32 - addr_bits);
    t    = (u * HALF_PI_Q30) >> 30;
    t2   = (t * t) >> 30;
    term = t;
    sum  = signed'(t);
    term = ((term * t2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * t2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * t2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    if (sum < 0) begin
      sum = 64'sd0;
    end
    q15 = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return q15[AMP_W-1:0];
  endfunction

endpackage

@@ design/dtg_tone_if.sv @@
// Request channel carrying one sample tick with its tone_on flag.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface dtg_tone_if;
  logic valid;
  logic ready;
  logic tone_on;

  modport source (output valid, output tone_on, input ready);
  modport sink (input valid, input tone_on, output ready);
endinterface

@@ design/dtg_sample_if.sv @@
// Result channel carrying one signed 16-bit PCM sample.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface dtg_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ design/dtg_cfg_regs.sv @@
// Configuration register file: tone steps and amplitudes behind a write port.
// Depends on dtg_pkg.
`timescale 1ns / 1ps

module dtg_cfg_regs (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  dtg_pkg::cfg_idx_e      cfg_idx_i,
  input  logic [dtg_pkg::CFG_W-1:0] cfg_data_i,
  output dtg_pkg::dtg_cfg_t      cfg_o
);
  import dtg_pkg::*;

  dtg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_ONE: cfg_d.step_one = cfg_data_i[STEP_W-1:0];
        CFG_STEP_TWO: cfg_d.step_two = cfg_data_i[STEP_W-1:0];
        CFG_AMP_ONE:  cfg_d.amp_one  = cfg_data_i[AMP_W-1:0];
        CFG_AMP_TWO:  cfg_d.amp_two  = cfg_data_i[AMP_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_one <= '0;
      cfg_q.step_two <= '0;
      cfg_q.amp_one  <= AMP_RESET;
      cfg_q.amp_two  <= AMP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/dtg_sine_lut.sv @@
// Sine lookup from a quarter-wave constant table, addressed by the top phase
// bits and unfolded by quadrant. Depends on dtg_pkg.
`timescale 1ns / 1ps

module dtg_sine_lut #(
  parameter int PHASE_BITS      = dtg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = dtg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic [PHASE_BITS-1:0]            phase_i,
  input  logic                             en_i,
  output logic signed [dtg_pkg::SINE_W-1:0] sine_o
);
  import dtg_pkg::*;

  localparam int QSIZE  = 1 << (TABLE_ADDR_BITS - 2);
  localparam int ADDR_W = TABLE_ADDR_BITS - 1;

  logic [AMP_W-1:0]           qtab [QSIZE+1];
  logic [TABLE_ADDR_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [ADDR_W-1:0]          r_ext;
  logic [ADDR_W-1:0]          addr;
  logic signed [SINE_W-1:0]   mag;

  for (genvar k = 0; k <= QSIZE; k++) begin : g_qtab
    assign qtab[k] = quarter_sine(k, TABLE_ADDR_BITS);
  end

  assign idx   = phase_i[PHASE_BITS-1 -: TABLE_ADDR_BITS];
  assign quad  = idx[TABLE_ADDR_BITS-1 -: 2];
  assign r_ext = {1'b0, idx[TABLE_ADDR_BITS-3:0]};
  // Odd quadrants run the quarter wave backwards.
  assign addr  = quad[0] ? (ADDR_W'(QSIZE) - r_ext) : r_ext;
  assign mag   = signed'({1'b0, qtab[addr]});

  always_comb begin
    if (!en_i) begin
      sine_o = '0;
    end else if (quad[1]) begin
      sine_o = -mag;
    end else begin
      sine_o = mag;
    end
  end

endmodule

@@ design/dtg_mix_sat.sv @@
// Output stage: scales both sines, sums, truncates toward zero, saturates and
// holds the sample in the result register. Depends on dtg_pkg, dtg_sample_if.
`timescale 1ns / 1ps

module dtg_mix_sat (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [dtg_pkg::SINE_W-1:0] sin_one_i,
  input  logic signed [dtg_pkg::SINE_W-1:0] sin_two_i,
  input  logic [dtg_pkg::AMP_W-1:0]         amp_one_i,
  input  logic [dtg_pkg::AMP_W-1:0]         amp_two_i,
  dtg_sample_if.source                      sample_o
);
  import dtg_pkg::*;

  localparam logic signed [32:0] SAT_MAX = 33'sd32767;
  localparam logic signed [32:0] SAT_MIN = -33'sd32768;

  logic signed [31:0]       prod_one;
  logic signed [31:0]       prod_two;
  logic signed [32:0]       acc;
  logic signed [32:0]       bias;
  logic signed [32:0]       scaled;
  logic signed [SAMPLE_W-1:0] sample_d, sample_q;
  logic                     valid_d, valid_q;
  logic                     load;

  assign prod_one = 32'(sin_one_i) * 32'(signed'({1'b0, amp_one_i}));
  assign prod_two = 32'(sin_two_i) * 32'(signed'({1'b0, amp_two_i}));
  assign acc      = 33'(prod_one) + 33'(prod_two);
  // Adding 2^15-1 before the arithmetic shift rounds negative sums toward zero.
  assign bias     = acc[32] ? 33'sd32767 : 33'sd0;
  assign scaled   = (acc + bias) >>> 15;

  always_comb begin
    priority if (scaled > SAT_MAX) begin
      sample_d = SAT_MAX[SAMPLE_W-1:0];
    end else if (scaled < SAT_MIN) begin
      sample_d = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sample_d = scaled[SAMPLE_W-1:0];
    end
  end

  assign ready_o = !valid_q || sample_o.ready;
  assign load    = valid_i && ready_o;
  assign valid_d = load ? 1'b1 : (sample_o.ready ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o.valid  = valid_q;
  assign sample_o.sample = sample_q;

endmodule

@@ design/dual_tone_generator.sv @@
// Dual-tone generator core. A request passes two registered stages before its
// result is valid: the sine table stage, then the multiply and saturate stage.
// Throughput: one request per cycle unless back-pressure from the result side stalls.
// Reset: phases and tone steps clear to zero, amplitudes return to 8000, both
// stages empty.
`timescale 1ns / 1ps

module dual_tone_generator_core #(
  parameter int PHASE_BITS      = dtg_pkg::PHASE_BITS_DEF,
  parameter int TABLE_ADDR_BITS = dtg_pkg::TABLE_ADDR_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  dtg_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [dtg_pkg::CFG_W-1:0] cfg_data_i,
  dtg_tone_if.sink                  tone_i,
  dtg_sample_if.source              sample_o
);
  import dtg_pkg::*;

  dtg_cfg_t                 cfg;
  logic [PHASE_BITS-1:0]    phase_one_q, phase_one_d;
  logic [PHASE_BITS-1:0]    phase_two_q, phase_two_d;
  logic signed [SINE_W-1:0] sin_one, sin_two;
  logic signed [SINE_W-1:0] sin_one_q, sin_two_q;
  logic                     s1_valid_q, s1_valid_d;
  logic                     mix_ready;
  logic                     accept;

  dtg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dtg_sine_lut #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_lut_one (
    .phase_i (phase_one_q),
    .en_i    (tone_i.tone_on),
    .sine_o  (sin_one)
  );

  dtg_sine_lut #(
    .PHASE_BITS      (PHASE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_lut_two (
    .phase_i (phase_two_q),
    .en_i    (tone_i.tone_on),
    .sine_o  (sin_two)
  );

  assign tone_i.ready = !s1_valid_q || mix_ready;
  assign accept       = tone_i.valid && tone_i.ready;
  assign s1_valid_d   = accept ? 1'b1 : (mix_ready ? 1'b0 : s1_valid_q);

  // The sample uses the phases before this request advances them.
  always_comb begin
    phase_one_d = phase_one_q;
    phase_two_d = phase_two_q;
    if (accept && tone_i.tone_on) begin
      phase_one_d = phase_one_q + PHASE_BITS'(cfg.step_one);
      phase_two_d = phase_two_q + PHASE_BITS'(cfg.step_two);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_one_q <= '0;
      phase_two_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_one_q <= phase_one_d;
      phase_two_q <= phase_two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sin_one_q <= sin_one;
      sin_two_q <= sin_two;
    end
  end

  dtg_mix_sat u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s1_valid_q),
    .ready_o   (mix_ready),
    .sin_one_i (sin_one_q),
    .sin_two_i (sin_two_q),
    .amp_one_i (cfg.amp_one),
    .amp_two_i (cfg.amp_two),
    .sample_o  (sample_o)
  );

endmodule

@@ tb/dual_tone_generator_core_tb.sv @@
// Self-checking testbench for dual_tone_generator_core: predicts every PCM sample
// from its own sine table and phase accumulators. Depends on dtg_pkg and the
// dtg_tone_if / dtg_sample_if channel interfaces of the design.
`timescale 1ns / 1ps

module dual_tone_generator_core_tb;
  import dtg_pkg::*;

  localparam int TBL_BITS     = TABLE_ADDR_BITS_DEF;
  localparam int TBL_SIZE     = 1 << TBL_BITS;
  localparam int QTR          = 1 << (TBL_BITS - 2);
  localparam int LIMIT_CYCLES = 200000;
  localparam int IDLE_PCT     = 31;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  cfg_idx_e          cfg_idx_i;
  logic [CFG_W-1:0]  cfg_data_i;

  dtg_tone_if   tone_if ();
  dtg_sample_if samp_if ();

  dual_tone_generator_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .tone_i    (tone_if),
    .sample_o  (samp_if)
  );

  // Predictor state: configuration and both phase accumulators.
  logic [STEP_W-1:0]          step_a;
  logic [STEP_W-1:0]          step_b;
  logic [AMP_W-1:0]           amp_a;
  logic [AMP_W-1:0]           amp_b;
  logic [PHASE_BITS_DEF-1:0]  phase_a;
  logic [PHASE_BITS_DEF-1:0]  phase_b;
  logic signed [SAMPLE_W-1:0] sine_lut [TBL_SIZE];

  logic signed [SAMPLE_W-1:0] expected_samples [$];
  int unsigned                mismatches;
  int unsigned                cycles;
  bit                         steady;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[dual_tone_generator_core] ERROR");
      $finish;
    end
  end

  // Quarter-wave sine in Q15 from an eleventh-order Taylor series in Q30.
  function automatic logic signed [SAMPLE_W-1:0] quarter_wave(input int unsigned r);
    logic [63:0]        ang;
    logic [63:0]        ang_sq;
    logic [63:0]        term;
    logic [63:0]        q15;
    logic signed [63:0] acc;
    int                 n;
    ang    = ((64'(r) << (32 - TBL_BITS)) * HALF_PI_Q30) >> 30;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = signed'(ang);
    for (n = 1; n <= 5; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - signed'(term);
      end else begin
        acc = acc + signed'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    q15 = (unsigned'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return SAMPLE_W'(q15);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] mix_tones(
      input logic [PHASE_BITS_DEF-1:0] pa, input logic [PHASE_BITS_DEF-1:0] pb);
    longint acc;
    longint mag;
    longint res;
    acc = longint'(sine_lut[pa[PHASE_BITS_DEF-1 -: TBL_BITS]]) * longint'(amp_a)
        + longint'(sine_lut[pb[PHASE_BITS_DEF-1 -: TBL_BITS]]) * longint'(amp_b);
    mag = (acc < 0) ? -acc : acc;
    mag = mag >>> 15;
    res = (acc < 0) ? -mag : mag;
    if (res > 32767) begin
      res = 32767;
    end
    if (res < -32768) begin
      res = -32768;
    end
    return SAMPLE_W'(res);
  endfunction

  task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] want,
                                 input logic signed [SAMPLE_W-1:0] got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // Result side: random back-pressure, and every accepted sample is compared
  // with the oldest prediction.
  initial begin
    samp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && samp_if.valid && samp_if.ready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample with no request pending", 'x, samp_if.sample);
        end else if (samp_if.sample !== expected_samples[0]) begin
          report_mismatch("sample", expected_samples.pop_front(), samp_if.sample);
        end else begin
          void'(expected_samples.pop_front());
        end
      end
      samp_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_STEP_ONE: step_a = data[STEP_W-1:0];
      CFG_STEP_TWO: step_b = data[STEP_W-1:0];
      CFG_AMP_ONE:  amp_a  = data[AMP_W-1:0];
      CFG_AMP_TWO:  amp_b  = data[AMP_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(input logic [CFG_W-1:0] s1, input logic [CFG_W-1:0] s2,
                           input logic [CFG_W-1:0] a1, input logic [CFG_W-1:0] a2);
    write_reg(CFG_STEP_ONE, s1);
    write_reg(CFG_STEP_TWO, s2);
    write_reg(CFG_AMP_ONE, a1);
    write_reg(CFG_AMP_TWO, a2);
  endtask

  // Sends one sample tick and records its predicted sample on acceptance.
  task automatic send_tick(input logic on);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      tone_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tone_if.valid   <= 1'b1;
    tone_if.tone_on <= on;
    do begin
      @(posedge clk_i);
    end while (!tone_if.ready);
    if (on) begin
      expected_samples.push_back(mix_tones(phase_a, phase_b));
      phase_a = phase_a + step_a;
      phase_b = phase_b + step_b;
    end else begin
      expected_samples.push_back('0);
    end
  endtask

  // Holds requests back until every predicted sample has come out.
  task automatic drain_requests();
    tone_if.valid <= 1'b0;
    while (expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] pick_step();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h00FF_FFFF, 0);
      2: return 32'hFFFF_FFFF - $urandom_range(32'h000F_FFFF, 0);
      default: return {2'($urandom_range(3, 0)), 30'd0} | $urandom_range(3, 0);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_amp();
    case ($urandom_range(3))
      0: return 32'h0000_7FFF;
      1: return {17'($urandom), 15'd0};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    // Zero steps keep both phases at zero, so a tone sample is silent too.
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain_requests();
  endtask

  task automatic test_directed();
    int k;
    // Quarter-turn steps at full amplitude walk through zero and both
    // saturation limits; the register data carries bits above the field.
    write_all(32'h4000_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'hFFFF_7FFF);
    for (k = 0; k < 4; k++) begin
      send_tick(1'b1);
    end
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_requests();
    // Largest step on one tone with the other muted.
    write_all(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_7FFF);
    for (k = 0; k < 4; k++) begin
      send_tick(1'b1);
    end
    drain_requests();
    write_all(32'h1234_5678, 32'h8000_0001, 32'h0000_0001, 32'h0000_0000);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain_requests();
  endtask

  task automatic test_random(input int unsigned n_phases, input int unsigned per_phase);
    int unsigned p;
    int unsigned i;
    for (p = 0; p < n_phases; p++) begin
      write_all(pick_step(), pick_step(), pick_amp(), pick_amp());
      steady = (p == 2);
      for (i = 0; i < per_phase; i++) begin
        send_tick($urandom_range(99) < 80);
        if (p == 1 && i == per_phase / 2) begin
          drain_requests();
        end
      end
      steady = 1'b0;
      drain_requests();
    end
  endtask

  initial begin
    int k;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_STEP_ONE;
    cfg_data_i      = '0;
    tone_if.valid   = 1'b0;
    tone_if.tone_on = 1'b0;
    mismatches      = 0;
    cycles          = 0;
    steady          = 1'b0;
    step_a          = '0;
    step_b          = '0;
    amp_a           = AMP_RESET;
    amp_b           = AMP_RESET;
    phase_a         = '0;
    phase_b         = '0;
    // Full table from the quarter wave: odd quadrants mirror, upper half negates.
    for (k = 0; k < TBL_SIZE; k++) begin
      if ((k / QTR) % 2 == 1) begin
        sine_lut[k] = quarter_wave(QTR - (k % QTR));
      end else begin
        sine_lut[k] = quarter_wave(k % QTR);
      end
      if (k >= TBL_SIZE / 2) begin
        sine_lut[k] = -sine_lut[k];
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_directed();
    test_random(5, 230);

    drain_requests();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("[dual_tone_generator_core] OK");
    end else begin
      $display("[dual_tone_generator_core] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/dtg_pkg.sv
design/dtg_tone_if.sv
design/dtg_sample_if.sv
design/dtg_cfg_regs.sv
design/dtg_sine_lut.sv
design/dtg_mix_sat.sv
design/dual_tone_generator.sv
tb/dual_tone_generator_core_tb.sv
